// ----- design/lfu_pkg.sv -----
// shared types and constants for the lfu cache table
package lfu_pkg;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned ADDR_W  = 1;
  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 5'd16;

  // command broadcast from the sequencer to every cell
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOOKUP,
    CMD_TOUCH,
    CMD_WRITE_TOUCH,
    CMD_REMOVE,
    CMD_INSERT
  } cell_cmd_t;
endpackage

// ----- design/lfu_if.sv -----
// valid/ready stream interfaces for the request and result channels
interface lfu_req_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;
  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lfu_rsp_if;
  import lfu_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic signed [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ----- design/lfu_cell.sv -----
// one cache slot: key, value, count and recency rank, plus its link in the scan chain
module lfu_cell import lfu_pkg::*; #(
  parameter int unsigned RANK_W  = 4,
  parameter int unsigned COUNT_W = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_cmd_t           cmd,
  input  logic                sel,        // this cell is the target slot
  input  logic [RANK_W-1:0]   ref_rank,   // rank of the target before the op
  input  logic [KEY_W-1:0]    cmd_key,
  input  logic [VAL_W-1:0]    cmd_value,
  // scan chain: shift in from neighbor, out to the next cell
  input  logic                scan_shift,
  input  logic                scan_load,
  input  logic                sin_valid,
  input  logic [KEY_W-1:0]    sin_key,
  input  logic [VAL_W-1:0]    sin_value,
  input  logic [COUNT_W-1:0]  sin_count,
  input  logic [RANK_W-1:0]   sin_rank,
  output logic                sout_valid,
  output logic [KEY_W-1:0]    sout_key,
  output logic [VAL_W-1:0]    sout_value,
  output logic [COUNT_W-1:0]  sout_count,
  output logic [RANK_W-1:0]   sout_rank
);
  logic               valid_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   value_r;
  logic [COUNT_W-1:0] count_r;
  logic [RANK_W-1:0]  rank_r;
  logic               sv_r;
  logic [KEY_W-1:0]   sk_r;
  logic [VAL_W-1:0]   sval_r;
  logic [COUNT_W-1:0] sc_r;
  logic [RANK_W-1:0]  sr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      if (scan_load) begin
        sv_r <= valid_r; sk_r <= key_r; sval_r <= value_r; sc_r <= count_r; sr_r <= rank_r;
      end else if (scan_shift) begin
        sv_r <= sin_valid; sk_r <= sin_key; sval_r <= sin_value; sc_r <= sin_count;
        sr_r <= sin_rank;
      end
      case (cmd) inside
        CMD_TOUCH, CMD_WRITE_TOUCH: begin
          if (sel) begin
            rank_r <= '0;
            if (count_r != '1) count_r <= count_r + 1'b1;
            if (cmd == CMD_WRITE_TOUCH) value_r <= cmd_value;
          end else if (valid_r && rank_r < ref_rank) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (sel) valid_r <= 1'b0;
          else if (valid_r && rank_r > ref_rank) rank_r <= rank_r - 1'b1;
        end
        CMD_INSERT: begin
          if (sel) begin
            valid_r <= 1'b1; key_r <= cmd_key; value_r <= cmd_value;
            count_r <= COUNT_W'(1); rank_r <= '0;
          end else if (valid_r) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign sout_valid = sv_r;
  assign sout_key   = sk_r;
  assign sout_value = sval_r;
  assign sout_count = sc_r;
  assign sout_rank  = sr_r;
endmodule

// ----- design/lfu_cache_table.sv -----
// lfu cache table top level: request sequencer, row of slot cells, config register
// Each request steps through the sequencer states in order: a load state copies a snapshot
// of every slot into the cells' scan registers, then the scan state shifts that snapshot
// past the sequencer one slot per cycle, where the key match, the used count, the first
// free slot and the lowest-count/oldest victim are gathered; the apply state updates all
// cells at once, a put that has to evict adds an evict state that inserts the new entry,
// the output state loads the result register and the idle state takes the next request.
// The result sits in an output register, so the next request is taken while it waits;
// the sequencer only stalls in its output state when the previous result has still not
// been taken.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  lfu_req_if.sink           in_if,
  lfu_rsp_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W+1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);

  // configuration register
  logic [CAP_W-1:0] capacity_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) capacity_r <= CAP_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr[ADDR_W+1:2] == REG_CAPACITY)
      capacity_r <= cfg_pwdata[CAP_W-1:0];
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[ADDR_W+1:2] == REG_CAPACITY) cfg_prdata[CAP_W-1:0] = capacity_r;
  end

  // effective capacity, clamped to depth
  logic [CNT_W-1:0] cap_eff;
  always_comb begin
    if (32'(capacity_r) > 32'(MAX_ENTRIES)) cap_eff = CNT_W'(MAX_ENTRIES);
    else cap_eff = CNT_W'(capacity_r);
  end

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_APPLY, S_EVICT, S_OUT} state_t;
  state_t state_r;

  // latched request
  logic             kind_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;

  // scan results
  logic [IDX_W:0]     scan_cnt_r;
  logic               found_r;
  logic [IDX_W-1:0]   found_idx_r;
  logic [RANK_W-1:0]  found_rank_r;
  logic [VAL_W-1:0]   found_val_r;
  logic [CNT_W-1:0]   used_r;
  logic               free_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               vic_r;
  logic [IDX_W-1:0]   vic_idx_r;
  logic [COUNT_BITS-1:0] vic_cnt_r;
  logic [RANK_W-1:0]  vic_rank_r;
  logic [KEY_W-1:0]   vic_key_r;

  // result register
  logic               o_valid_r;
  logic               o_hit_r;
  logic [VAL_W-1:0]   o_rd_r;
  logic               o_ev_r;
  logic [KEY_W-1:0]   o_evk_r;

  // cell row wiring; the chain shifts toward cell 0, whose output the sequencer reads
  cell_cmd_t          cmd;
  logic [IDX_W-1:0]   tgt;
  logic [RANK_W-1:0]  ref_rank;
  logic               scan_load, scan_shift;
  logic               cv   [MAX_ENTRIES];
  logic [KEY_W-1:0]   ck   [MAX_ENTRIES];
  logic [VAL_W-1:0]   cval [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cc [MAX_ENTRIES];
  logic [RANK_W-1:0]  cr   [MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic               nv;
    logic [KEY_W-1:0]   nk;
    logic [VAL_W-1:0]   nval;
    logic [COUNT_BITS-1:0] nc;
    logic [RANK_W-1:0]  nr;
    if (g == MAX_ENTRIES - 1) begin : g_end
      assign nv = 1'b0; assign nk = '0; assign nval = '0; assign nc = '0; assign nr = '0;
    end else begin : g_mid
      assign nv = cv[g+1]; assign nk = ck[g+1]; assign nval = cval[g+1];
      assign nc = cc[g+1]; assign nr = cr[g+1];
    end
    lfu_cell #(.RANK_W(RANK_W), .COUNT_W(COUNT_BITS)) u_cell (
      .clk, .rst_n, .cmd,
      .sel       (tgt == IDX_W'(g)),
      .ref_rank,
      .cmd_key   (key_r),
      .cmd_value (value_r),
      .scan_shift, .scan_load,
      .sin_valid (nv), .sin_key (nk), .sin_value (nval), .sin_count (nc), .sin_rank (nr),
      .sout_valid(cv[g]), .sout_key(ck[g]), .sout_value(cval[g]), .sout_count(cc[g]),
      .sout_rank (cr[g])
    );
  end

  // slot index currently at the head of the chain
  logic [IDX_W-1:0] scan_idx;
  assign scan_idx = scan_cnt_r[IDX_W-1:0];

  logic need_evict;
  assign need_evict = !found_r && (used_r >= cap_eff);

  // a put to a missing key that has to make room first
  logic evict_op;
  assign evict_op = !found_r && kind_r == KIND_PUT && cap_eff != '0 && need_evict && vic_r;

  // in the output state, the result register loads when empty or when its transfer happens this cycle
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!o_valid_r || out_if.ready);

  // command decode for the cells
  always_comb begin
    cmd        = CMD_NONE;
    tgt        = found_idx_r;
    ref_rank   = found_rank_r;
    scan_load  = (state_r == S_LOAD);
    scan_shift = (state_r == S_SCAN);
    unique case (state_r)
      S_APPLY: begin
        if (found_r) begin
          if (kind_r == KIND_GET) cmd = CMD_TOUCH;
          else if (cap_eff != '0) cmd = CMD_WRITE_TOUCH;
        end else if (kind_r == KIND_PUT && cap_eff != '0) begin
          if (need_evict && vic_r) begin
            cmd = CMD_REMOVE; tgt = vic_idx_r; ref_rank = vic_rank_r;
          end else if (free_r) begin
            cmd = CMD_INSERT; tgt = free_idx_r;
          end
        end
      end
      S_EVICT: begin
        // the evicted slot is the lowest free slot only if no lower one was free
        cmd = CMD_INSERT;
        tgt = (free_r && free_idx_r < vic_idx_r) ? free_idx_r : vic_idx_r;
      end
      default: ;
    endcase
  end

  assign in_if.ready      = (state_r == S_IDLE);
  assign out_if.valid       = o_valid_r;
  assign out_if.hit         = o_hit_r;
  assign out_if.read_value  = o_rd_r;
  assign out_if.evicted     = o_ev_r;
  assign out_if.evicted_key = o_evk_r;

  logic better;
  always_comb begin
    better = !vic_r || cc[0] < vic_cnt_r || (cc[0] == vic_cnt_r && cr[0] > vic_rank_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      o_valid_r <= 1'b0;
    end else begin
      if (out_load) o_valid_r <= 1'b1;
      else if (o_valid_r && out_if.ready) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            kind_r  <= in_if.kind;
            key_r   <= in_if.key;
            value_r <= in_if.value;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          scan_cnt_r <= '0;
          found_r <= 1'b0; free_r <= 1'b0; vic_r <= 1'b0; used_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          // head of the chain shows slot scan_idx this cycle
          if (cv[0]) begin
            used_r <= used_r + 1'b1;
            if (!found_r && ck[0] == key_r) begin
              found_r <= 1'b1; found_idx_r <= scan_idx;
              found_rank_r <= cr[0]; found_val_r <= cval[0];
            end
            if (better) begin
              vic_r <= 1'b1; vic_idx_r <= scan_idx; vic_cnt_r <= cc[0];
              vic_rank_r <= cr[0]; vic_key_r <= ck[0];
            end
          end else if (!free_r) begin
            free_r <= 1'b1; free_idx_r <= scan_idx;
          end
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == (IDX_W+1)'(MAX_ENTRIES - 1)) state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (evict_op) state_r <= S_EVICT;
          else state_r <= S_OUT;
        end
        S_EVICT: state_r <= S_OUT;
        S_OUT: begin
          // wait here while the previous result is still not taken
          if (out_load) begin
            o_hit_r <= found_r;
            o_rd_r  <= (found_r && kind_r == KIND_GET) ? found_val_r : '0;
            o_ev_r  <= evict_op;
            o_evk_r <= evict_op ? vic_key_r : '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_if.ready) else $error("accept while busy");
  a_evict_is_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(o_valid_r) && o_ev_r |-> kind_r == KIND_PUT && !o_hit_r)
    else $error("eviction without missing put");
  a_out_after_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(o_valid_r) |-> $past(state_r) == S_OUT) else $error("stray result");
`endif
endmodule
